// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// SNMP flow detector package
// Shared constants, codes and types of the SNMP flow detector.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int FLOW_SLOTS = 256;
    localparam int SLOT_AW    = $clog2(FLOW_SLOTS);
    localparam int HDR_LEN    = 21;
    localparam int CNT_W      = $clog2(HDR_LEN + 1);
    localparam int CFG_W      = 16;

    localparam logic [15:0] AGENT_PORT_RST = 16'd161;
    localparam logic [15:0] TRAP_PORT_RST  = 16'd162;
    localparam logic [15:0] MIN_LEN        = 16'd32;

    localparam logic [7:0] SEQ_TAG   = 8'h30;
    localparam logic [7:0] LEN_LONG1 = 8'h81;
    localparam logic [7:0] LEN_LONG2 = 8'h82;
    localparam logic [7:0] INT_TAG   = 8'h02;
    localparam logic [7:0] INT_LEN   = 8'h01;
    localparam logic [7:0] VER_LIMIT = 8'h04;
    localparam logic [7:0] VER_V1    = 8'h00;
    localparam logic [7:0] VER_V3    = 8'h03;

    localparam logic [1:0] STAGE_NONE      = 2'd0;
    localparam logic [1:0] STAGE_FROM_DIR0 = 2'd1;
    localparam logic [1:0] STAGE_FROM_DIR1 = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_SKIP    = 2'd0,
        VERDICT_DETECT  = 2'd1,
        VERDICT_RECORD  = 2'd2,
        VERDICT_EXCLUDE = 2'd3
    } t_verdict;

    typedef enum logic {
        CFG_AGENT_PORT = 1'b0,
        CFG_TRAP_PORT  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        excluded;
        logic [1:0]  stage;
        logic [15:0] msg_id;
    } t_flow_entry;

    typedef struct packed {
        logic [7:0]  flow_slot;
        logic        first_byte;
        logic        last_byte;
        logic [7:0]  data_byte;
        logic [15:0] payload_length;
        logic        direction;
        logic [15:0] dest_port;
        logic        eligible;
        logic        flow_restart;
    } t_item;

endpackage

// ===== rtl/sfd_item_if.sv =====
// ----------------------------------------------------------------------------
// SNMP flow detector input channel
// Valid/ready channel carrying one UDP payload byte with its packet facts.
// ----------------------------------------------------------------------------
interface sfd_item_if;

    logic        valid;
    logic        ready;
    logic [7:0]  flow_slot;
    logic        first_byte;
    logic        last_byte;
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic        direction;
    logic [15:0] dest_port;
    logic        eligible;
    logic        flow_restart;

    modport source (
        output valid, flow_slot, first_byte, last_byte, data_byte,
               payload_length, direction, dest_port, eligible, flow_restart,
        input  ready
    );

    modport sink (
        input  valid, flow_slot, first_byte, last_byte, data_byte,
               payload_length, direction, dest_port, eligible, flow_restart,
        output ready
    );

endinterface

// ===== rtl/sfd_result_if.sv =====
// ----------------------------------------------------------------------------
// SNMP flow detector result channel
// Valid/ready channel carrying one verdict and the flow slot it refers to.
// ----------------------------------------------------------------------------
interface sfd_result_if;

    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [7:0] result_slot;

    modport source (
        output valid, verdict, result_slot,
        input  ready
    );

    modport sink (
        input  valid, verdict, result_slot,
        output ready
    );

endinterface

// ===== rtl/snmp_flow_detector.sv =====
// ----------------------------------------------------------------------------
// SNMP flow detector
// Per-flow SNMP recognizer over a stream of UDP payload bytes.
// ----------------------------------------------------------------------------
// The block accepts one payload byte item per clock cycle, with no gaps needed
// between items or packets. Each item passes an input register and, at the
// last byte of a packet, a result register, which then presents the verdict.
// A last byte waits in the input register while an earlier verdict is still
// held in the result register and not taken, and the input stalls for that
// time. The per-flow stage, message ID and exclusion mark live in a 256-entry
// memory that is read when an item is accepted and written when the item is
// retired; entries never written read as zero through per-entry valid bits,
// so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module snmp_flow_detector (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  sfd_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [sfd_pkg::CFG_W-1:0] i_cfg_data,
    sfd_item_if.sink                 i_item,
    sfd_result_if.source             o_result
);
    import sfd_pkg::*;

    logic [15:0]  r_agent_port;
    logic [15:0]  r_trap_port;

    t_item        w_in_item;
    t_item        r_in;
    logic         r_in_valid;
    logic         w_accept;
    logic         w_fire;
    logic [SLOT_AW-1:0] r_acc_slot;
    logic [SLOT_AW-1:0] w_rd_addr;

    t_flow_entry  r_mem [FLOW_SLOTS];
    t_flow_entry  r_mem_q;
    logic [FLOW_SLOTS-1:0] r_valid;
    logic         r_rd_valid;
    logic         r_fwd;
    t_flow_entry  r_fwd_entry;

    logic         w_we;
    logic [SLOT_AW-1:0] w_waddr;
    t_flow_entry  w_wdata;

    logic [7:0]   r_pk_slot;
    logic [15:0]  r_pk_len;
    logic [15:0]  r_pk_port;
    logic         r_pk_dir;
    logic         r_pk_elig;
    logic         r_pk_open;
    logic [CNT_W-1:0] r_byte_count;
    logic [7:0]   r_hdr [HDR_LEN];

    logic [7:0]   n_pk_slot;
    logic [15:0]  n_pk_len;
    logic [15:0]  n_pk_port;
    logic         n_pk_dir;
    logic         n_pk_elig;
    logic         n_pk_open;
    logic [CNT_W-1:0] n_byte_count;
    logic [7:0]   n_hdr [HDR_LEN];
    logic         w_open;
    logic [CNT_W-1:0] w_cnt;

    t_flow_entry  w_cur;
    logic [7:0]   w_int_tag;
    logic [7:0]   w_int_len;
    logic [7:0]   w_ver;
    logic [7:0]   w_v3_hi;
    logic [7:0]   w_v3_lo;
    logic [7:0]   w_v12_hi;
    logic [7:0]   w_v12_lo;
    logic [15:0]  w_msg_id;
    logic         w_hdr_ok;
    logic         w_changed;
    t_verdict     w_verdict;

    logic         r_out_valid;
    t_verdict     r_out_verdict;
    logic [7:0]   r_out_slot;

    assign w_in_item = '{
        flow_slot:      i_item.flow_slot,
        first_byte:     i_item.first_byte,
        last_byte:      i_item.last_byte,
        data_byte:      i_item.data_byte,
        payload_length: i_item.payload_length,
        direction:      i_item.direction,
        dest_port:      i_item.dest_port,
        eligible:       i_item.eligible,
        flow_restart:   i_item.flow_restart
    };

    assign w_fire   = r_in_valid && (!r_in.last_byte || !r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_fire;
    assign w_accept = i_item.valid && i_item.ready;
    assign w_rd_addr = w_in_item.first_byte ? w_in_item.flow_slot[SLOT_AW-1:0] : r_acc_slot;

    assign o_result.valid       = r_out_valid;
    assign o_result.verdict     = r_out_verdict;
    assign o_result.result_slot = r_out_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agent_port <= AGENT_PORT_RST;
            r_trap_port  <= TRAP_PORT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AGENT_PORT: r_agent_port <= i_cfg_data;
                CFG_TRAP_PORT:  r_trap_port  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_acc_slot <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_accept && w_in_item.first_byte) begin
                r_acc_slot <= w_in_item.flow_slot[SLOT_AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= w_in_item;
        end
    end

    // Flow table; a write retiring in the same cycle as a read is forwarded.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_mem_q     <= r_mem[w_rd_addr];
            r_fwd_entry <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_accept) begin
                r_rd_valid <= r_valid[w_rd_addr];
                r_fwd      <= w_we && (w_waddr == w_rd_addr);
            end
        end
    end

    always_comb begin
        w_open    = r_in.first_byte || r_pk_open;
        n_pk_slot = r_in.first_byte ? r_in.flow_slot      : r_pk_slot;
        n_pk_len  = r_in.first_byte ? r_in.payload_length : r_pk_len;
        n_pk_port = r_in.first_byte ? r_in.dest_port      : r_pk_port;
        n_pk_dir  = r_in.first_byte ? r_in.direction      : r_pk_dir;
        n_pk_elig = r_in.first_byte ? r_in.eligible       : r_pk_elig;
        n_pk_open = w_open && !r_in.last_byte;
        w_cnt     = r_in.first_byte ? '0 : r_byte_count;
        for (int k = 0; k < HDR_LEN; k++) begin
            n_hdr[k] = r_in.first_byte ? 8'h00 : r_hdr[k];
            if (w_open && (w_cnt == CNT_W'(k))) begin
                n_hdr[k] = r_in.data_byte;
            end
        end
        if (w_open && (w_cnt < CNT_W'(HDR_LEN))) begin
            n_byte_count = w_cnt + CNT_W'(1);
        end else begin
            n_byte_count = w_cnt;
        end
    end

    always_comb begin
        case (n_hdr[1])
            LEN_LONG1: begin
                w_int_tag = n_hdr[3];
                w_int_len = n_hdr[4];
                w_ver     = n_hdr[5];
                w_v3_hi   = n_hdr[11];
                w_v3_lo   = n_hdr[12];
                w_v12_hi  = n_hdr[18];
                w_v12_lo  = n_hdr[19];
            end
            LEN_LONG2: begin
                w_int_tag = n_hdr[4];
                w_int_len = n_hdr[5];
                w_ver     = n_hdr[6];
                w_v3_hi   = n_hdr[12];
                w_v3_lo   = n_hdr[13];
                w_v12_hi  = n_hdr[19];
                w_v12_lo  = n_hdr[20];
            end
            default: begin
                w_int_tag = n_hdr[2];
                w_int_len = n_hdr[3];
                w_ver     = n_hdr[4];
                w_v3_hi   = n_hdr[10];
                w_v3_lo   = n_hdr[11];
                w_v12_hi  = n_hdr[17];
                w_v12_lo  = n_hdr[18];
            end
        endcase
        if (w_ver == VER_V3) begin
            w_msg_id = {w_v3_hi, w_v3_lo};
        end else if (w_ver == VER_V1) begin
            w_msg_id = {8'h00, w_v12_hi};
        end else begin
            w_msg_id = {w_v12_hi, w_v12_lo};
        end
        w_hdr_ok = (n_pk_len > MIN_LEN) && (n_hdr[0] == SEQ_TAG) && (n_hdr[1] <= LEN_LONG2)
                   && (w_int_tag == INT_TAG) && (w_int_len == INT_LEN) && (w_ver < VER_LIMIT);
    end

    always_comb begin
        if (r_fwd) begin
            w_cur = r_fwd_entry;
        end else if (r_rd_valid) begin
            w_cur = r_mem_q;
        end else begin
            w_cur = '0;
        end
        if (r_in.first_byte && r_in.flow_restart) begin
            w_cur = '0;
        end
        w_wdata   = w_cur;
        w_changed = 1'b0;
        w_verdict = VERDICT_SKIP;
        if (r_in.last_byte && w_open && n_pk_elig && !w_cur.excluded) begin
            if (!w_hdr_ok) begin
                w_verdict = VERDICT_EXCLUDE;
            end else if (w_cur.stage == STAGE_NONE) begin
                if ((n_pk_port == r_agent_port) || (n_pk_port == r_trap_port)) begin
                    w_verdict = VERDICT_DETECT;
                end else begin
                    w_verdict = VERDICT_RECORD;
                end
            end else if ((w_cur.stage == (n_pk_dir ? STAGE_FROM_DIR0 : STAGE_FROM_DIR1))
                         && (w_cur.msg_id == w_msg_id)) begin
                w_verdict = VERDICT_DETECT;
            end else begin
                w_verdict = VERDICT_EXCLUDE;
            end
        end
        case (w_verdict)
            VERDICT_RECORD: begin
                w_wdata.msg_id = w_msg_id;
                w_wdata.stage  = n_pk_dir ? STAGE_FROM_DIR1 : STAGE_FROM_DIR0;
                w_changed      = 1'b1;
            end
            VERDICT_EXCLUDE: begin
                w_wdata.excluded = 1'b1;
                w_changed        = 1'b1;
            end
            default: begin
            end
        endcase
        w_waddr = n_pk_slot[SLOT_AW-1:0];
        w_we    = w_fire && ((r_in.first_byte && r_in.flow_restart) || w_changed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_open    <= 1'b0;
            r_pk_slot    <= '0;
            r_byte_count <= '0;
        end else if (w_fire) begin
            r_pk_open    <= n_pk_open;
            r_pk_slot    <= n_pk_slot;
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pk_len  <= n_pk_len;
            r_pk_port <= n_pk_port;
            r_pk_dir  <= n_pk_dir;
            r_pk_elig <= n_pk_elig;
            r_hdr     <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last_byte) begin
            r_out_verdict <= w_verdict;
            r_out_slot    <= n_pk_slot;
        end
    end

    // A result only appears after a last byte has been retired.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire && r_in.last_byte))
        else $error("result raised without a retired last byte");

    // Apart from a restart, the flow table only changes on record or exclude.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !(r_in.first_byte && r_in.flow_restart))
        |-> (w_verdict == VERDICT_RECORD || w_verdict == VERDICT_EXCLUDE))
        else $error("flow table written without a state-changing verdict");

    // The read address used at acceptance must follow the open packet's slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in.first_byte) |-> (r_acc_slot == r_pk_slot[SLOT_AW-1:0]))
        else $error("flow table read slot differs from the open packet slot");

endmodule

// ===== verif/snmp_flow_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SNMP flow detector testbench
// Drives payload byte items into the detector and checks every verdict
// against a cycle-free prediction of the per-flow SNMP recognizer. Traffic is
// mostly well-formed SNMP exchanges between a small pool of flows, mixed with
// broken headers, stray bytes and cut-off packets, under random idling, a
// long output stall and several port settings.
// ----------------------------------------------------------------------------
module snmp_flow_detector_tb;

    import sfd_pkg::*;

    typedef struct packed {
        t_verdict   verdict;
        logic [7:0] slot;
    } t_expected;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    sfd_item_if   item_if ();
    sfd_result_if res_if ();

    snmp_flow_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    // Predicted state of the detector.
    logic [1:0]  trk_stage    [FLOW_SLOTS];
    logic [15:0] trk_msg_id   [FLOW_SLOTS];
    logic        trk_excluded [FLOW_SLOTS];
    logic [7:0]  hdr_cap      [HDR_LEN];
    int unsigned hdr_cnt;
    logic [7:0]  pkt_slot;
    logic [15:0] pkt_len;
    logic [15:0] pkt_port;
    logic        pkt_dir;
    logic        pkt_elig;
    logic        pkt_open;
    logic [15:0] port_agent;
    logic [15:0] port_trap;

    t_expected   pending_verdicts [$];
    logic [7:0]  frame_buf [32];
    logic [7:0]  slot_pool [6];

    int          fail_count;
    int          bytes_accepted;
    int          settings_used;
    int          verdict_seen [4];
    int          hold_req;
    bit          src_no_idle;
    bit          sink_steady;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("snmp_flow_detector: mismatch");
        $finish;
    end

    function automatic logic [15:0] captured_msg_id(int unsigned off, logic [7:0] ver);
        if (ver == VER_V3) return {hdr_cap[off + 8], hdr_cap[off + 9]};
        if (ver == VER_V1) return {8'h00, hdr_cap[off + 15]};
        return {hdr_cap[off + 15], hdr_cap[off + 16]};
    endfunction

    function automatic t_verdict classify_packet();
        int unsigned off;
        logic [7:0]  ver;
        logic [1:0]  st;
        logic [7:0]  s;
        if (!pkt_open || int'(pkt_slot) >= FLOW_SLOTS || !pkt_elig) return VERDICT_SKIP;
        s = pkt_slot;
        if (trk_excluded[s]) return VERDICT_SKIP;
        off = 2;
        if (hdr_cap[1] == LEN_LONG1) off = 3;
        else if (hdr_cap[1] == LEN_LONG2) off = 4;
        ver = hdr_cap[off + 2];
        if (pkt_len <= MIN_LEN || hdr_cap[0] != SEQ_TAG || hdr_cap[1] > LEN_LONG2 ||
            hdr_cap[off] != INT_TAG || hdr_cap[off + 1] != INT_LEN || ver >= VER_LIMIT) begin
            trk_excluded[s] = 1'b1;
            return VERDICT_EXCLUDE;
        end
        st = trk_stage[s];
        if (st == STAGE_NONE) begin
            if (pkt_port == port_agent || pkt_port == port_trap) return VERDICT_DETECT;
            trk_msg_id[s] = captured_msg_id(off, ver);
            trk_stage[s] = pkt_dir ? STAGE_FROM_DIR1 : STAGE_FROM_DIR0;
            return VERDICT_RECORD;
        end
        if (st == (pkt_dir ? STAGE_FROM_DIR0 : STAGE_FROM_DIR1) &&
            trk_msg_id[s] == captured_msg_id(off, ver)) return VERDICT_DETECT;
        trk_excluded[s] = 1'b1;
        return VERDICT_EXCLUDE;
    endfunction

    function automatic void absorb_item(t_item it);
        t_expected want;
        if (it.first_byte) begin
            pkt_slot = it.flow_slot;
            pkt_len  = it.payload_length;
            pkt_dir  = it.direction;
            pkt_port = it.dest_port;
            pkt_elig = it.eligible;
            pkt_open = 1'b1;
            foreach (hdr_cap[i]) hdr_cap[i] = 8'h00;
            hdr_cnt = 0;
            if (it.flow_restart && int'(it.flow_slot) < FLOW_SLOTS) begin
                trk_stage[it.flow_slot]    = STAGE_NONE;
                trk_msg_id[it.flow_slot]   = 16'h0000;
                trk_excluded[it.flow_slot] = 1'b0;
            end
        end
        if (pkt_open && hdr_cnt < HDR_LEN) begin
            hdr_cap[hdr_cnt] = it.data_byte;
            hdr_cnt++;
        end
        if (it.last_byte) begin
            want.verdict = classify_packet();
            want.slot    = pkt_slot;
            pending_verdicts.push_back(want);
            pkt_open = 1'b0;
        end
    endfunction

    function automatic void load_frame(logic [63:0] bytes, int unsigned n);
        for (int unsigned i = 0; i < n; i++) frame_buf[i] = bytes[8 * (n - 1 - i) +: 8];
    endfunction

    function automatic void build_snmp_frame(int unsigned off, logic [7:0] ver,
                                             logic [15:0] id);
        foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
        frame_buf[0] = SEQ_TAG;
        if (off == 3) frame_buf[1] = LEN_LONG1;
        else if (off == 4) frame_buf[1] = LEN_LONG2;
        else frame_buf[1] = 8'($urandom_range(0, 128));
        frame_buf[off]     = INT_TAG;
        frame_buf[off + 1] = INT_LEN;
        frame_buf[off + 2] = ver;
        if (ver == VER_V3) begin
            frame_buf[off + 8] = id[15:8];
            frame_buf[off + 9] = id[7:0];
        end else if (ver == VER_V1) begin
            frame_buf[off + 15] = id[7:0];
        end else begin
            frame_buf[off + 15] = id[15:8];
            frame_buf[off + 16] = id[7:0];
        end
    endfunction

    task automatic send_item(input t_item it);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (!src_no_idle) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(10, 30);
            else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid          <= 1'b1;
        item_if.flow_slot      <= it.flow_slot;
        item_if.first_byte     <= it.first_byte;
        item_if.last_byte      <= it.last_byte;
        item_if.data_byte      <= it.data_byte;
        item_if.payload_length <= it.payload_length;
        item_if.direction      <= it.direction;
        item_if.dest_port      <= it.dest_port;
        item_if.eligible       <= it.eligible;
        item_if.flow_restart   <= it.flow_restart;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        absorb_item(it);
        bytes_accepted++;
    endtask

    task automatic send_frame(logic [7:0] slot, logic dir, logic [15:0] port,
                              logic [15:0] len, logic elig, logic restart,
                              int unsigned nbytes, bit close);
        t_item       it;
        logic [63:0] noise;
        for (int unsigned i = 0; i < nbytes; i++) begin
            noise = {$urandom, $urandom};
            it = t_item'(noise[$bits(t_item)-1:0]);
            it.first_byte = (i == 0);
            it.last_byte  = close && (i == nbytes - 1);
            it.data_byte  = (i < 32) ? frame_buf[i] : 8'($urandom_range(0, 255));
            if (i == 0) begin
                it.flow_slot      = slot;
                it.direction      = dir;
                it.dest_port      = port;
                it.payload_length = len;
                it.eligible       = elig;
                it.flow_restart   = restart;
            end
            send_item(it);
        end
    endtask

    task automatic send_stray(bit last);
        t_item       it;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        it = t_item'(noise[$bits(t_item)-1:0]);
        it.first_byte = 1'b0;
        it.last_byte  = last;
        send_item(it);
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ports(logic [15:0] agent, logic [15:0] trap);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_AGENT_PORT;
        i_cfg_data <= agent;
        @(posedge i_clk);
        port_agent = agent;
        i_cfg_idx  <= CFG_TRAP_PORT;
        i_cfg_data <= trap;
        @(posedge i_clk);
        port_trap = trap;
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_flow_traffic(int budget);
        int          start;
        int unsigned kind;
        int unsigned r;
        int unsigned off;
        int unsigned nbytes;
        logic [7:0]  slot;
        logic        dir;
        logic [15:0] id;
        logic [7:0]  ver;
        logic [15:0] port;
        logic [15:0] len;
        logic        restart;
        start = bytes_accepted;
        slot_pool[0] = 8'd0;
        slot_pool[1] = 8'd255;
        for (int i = 2; i < 6; i++) slot_pool[i] = 8'($urandom_range(0, 255));
        while (bytes_accepted - start < budget) begin
            slot = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255))
                                               : slot_pool[$urandom_range(0, 5)];
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                send_stray(1'($urandom_range(0, 1)));
            end else if (kind < 18) begin
                foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
                send_frame(slot, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), $urandom_range(0, 3) != 0,
                           $urandom_range(0, 19) == 0, $urandom_range(1, 25),
                           $urandom_range(0, 2) != 0);
            end else begin
                dir = 1'($urandom_range(0, 1));
                id  = 16'($urandom_range(0, 65535));
                if (trk_stage[slot] != STAGE_NONE && $urandom_range(0, 4) != 0) begin
                    dir = (trk_stage[slot] == STAGE_FROM_DIR0);
                    id  = trk_msg_id[slot];
                end
                ver = 8'($urandom_range(0, 3));
                off = $urandom_range(2, 4);
                build_snmp_frame(off, ver, id);
                if ($urandom_range(0, 99) < 12) begin
                    case ($urandom_range(0, 4))
                        0: frame_buf[0] = SEQ_TAG ^ 8'($urandom_range(1, 255));
                        1: frame_buf[1] = 8'($urandom_range(8'h83, 8'hFF));
                        2: frame_buf[off] = INT_TAG ^ 8'($urandom_range(1, 255));
                        3: frame_buf[off + 1] = INT_LEN ^ 8'($urandom_range(1, 255));
                        default: frame_buf[off + 2] = 8'($urandom_range(VER_LIMIT, 255));
                    endcase
                end
                nbytes = ($urandom_range(0, 99) < 60) ? $urandom_range(21, 27)
                                                      : $urandom_range(1, 20);
                r = $urandom_range(0, 99);
                if (r < 15) port = port_agent;
                else if (r < 25) port = port_trap;
                else if (r < 28) port = 16'h0000;
                else if (r < 31) port = 16'hFFFF;
                else port = 16'($urandom_range(0, 65535));
                r = $urandom_range(0, 99);
                if (r < 85) len = 16'($urandom_range(33, 1500));
                else if (r < 88) len = 16'd0;
                else if (r < 92) len = MIN_LEN;
                else if (r < 95) len = MIN_LEN + 16'd1;
                else if (r < 97) len = 16'hFFFF;
                else len = 16'($urandom_range(0, 65535));
                restart = trk_excluded[slot] ? ($urandom_range(0, 1) != 0)
                                             : ($urandom_range(0, 11) == 0);
                send_frame(slot, dir, port, len, $urandom_range(0, 12) != 0, restart,
                           nbytes, 1'b1);
            end
        end
        if (pkt_open) send_stray(1'b1);
    endtask

    task automatic test_directed_cases();
        send_stray(1'b0);
        send_stray(1'b1);
        load_frame(64'h30_00_02_01_00, 5);
        send_frame(8'd255, 1'b1, 16'd0, MIN_LEN + 16'd1, 1'b1, 1'b1, 5, 1'b1);
        load_frame(64'h30_7F_02_01_01, 5);
        send_frame(8'd255, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 5, 1'b1);
        load_frame(64'h30_81_00_02_01_02, 6);
        send_frame(8'd255, 1'b1, 16'd0, 16'd100, 1'b1, 1'b0, 6, 1'b1);
        load_frame(64'h30, 1);
        send_frame(8'd255, 1'b0, 16'd0, 16'd100, 1'b1, 1'b0, 1, 1'b1);
        send_frame(8'd0, 1'b0, 16'd0, MIN_LEN, 1'b1, 1'b0, 1, 1'b1);
        send_frame(8'd1, 1'b0, 16'd0, 16'd100, 1'b0, 1'b0, 1, 1'b1);
        load_frame(64'h30_83, 2);
        send_frame(8'd0, 1'b0, 16'd0, MIN_LEN + 16'd1, 1'b1, 1'b1, 2, 1'b1);
        load_frame(64'h30_00_02_01_03, 5);
        send_frame(8'd128, 1'b0, port_agent, MIN_LEN + 16'd1, 1'b1, 1'b0, 5, 1'b1);
    endtask

    task automatic test_default_ports();
        run_flow_traffic(300);
    endtask

    task automatic test_port_settings();
        logic [15:0] shared;
        shared = 16'($urandom_range(0, 65535));
        write_ports(16'h0000, 16'hFFFF);
        run_flow_traffic(230);
        write_ports(16'hFFFF, 16'h0000);
        run_flow_traffic(230);
        write_ports(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_flow_traffic(230);
        write_ports(shared, shared);
        run_flow_traffic(230);
        write_ports(AGENT_PORT_RST, TRAP_PORT_RST);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        hold_req = 150;
        src_no_idle = 1'b1;
        run_flow_traffic(220);
        src_no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_back_to_back();
        src_no_idle = 1'b1;
        sink_steady = 1'b1;
        run_flow_traffic(160);
        src_no_idle = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned r;
        stall_left = 0;
        run_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                run_left = 0;
                hold_req = 0;
            end
            if (stall_left == 0 && run_left == 0 && !sink_steady) begin
                r = $urandom_range(0, 99);
                if (r < 55) run_left = $urandom_range(1, 20);
                else if (r < 93) stall_left = $urandom_range(1, 3);
                else stall_left = $urandom_range(15, 40);
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (run_left > 0) run_left--;
            end
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        t_expected want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("result: no verdict expected, got %0d for slot %0d",
                       res_if.verdict, res_if.result_slot);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                verdict_seen[want.verdict]++;
                if (res_if.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, res_if.verdict);
                    fail_count++;
                end
                if (res_if.result_slot !== want.slot) begin
                    $error("result_slot: expected %0d, got %0d", want.slot,
                           res_if.result_slot);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_AGENT_PORT;
        i_cfg_data <= '0;
        item_if.valid          <= 1'b0;
        item_if.flow_slot      <= '0;
        item_if.first_byte     <= 1'b0;
        item_if.last_byte      <= 1'b0;
        item_if.data_byte      <= '0;
        item_if.payload_length <= '0;
        item_if.direction      <= 1'b0;
        item_if.dest_port      <= '0;
        item_if.eligible       <= 1'b0;
        item_if.flow_restart   <= 1'b0;
        foreach (trk_stage[i]) begin
            trk_stage[i]    = STAGE_NONE;
            trk_msg_id[i]   = 16'h0000;
            trk_excluded[i] = 1'b0;
        end
        foreach (hdr_cap[i]) hdr_cap[i] = 8'h00;
        foreach (verdict_seen[i]) verdict_seen[i] = 0;
        hdr_cnt        = 0;
        pkt_slot       = 8'h00;
        pkt_len        = 16'h0000;
        pkt_port       = 16'h0000;
        pkt_dir        = 1'b0;
        pkt_elig       = 1'b0;
        pkt_open       = 1'b0;
        port_agent     = AGENT_PORT_RST;
        port_trap      = TRAP_PORT_RST;
        fail_count     = 0;
        bytes_accepted = 0;
        settings_used  = 1;
        hold_req       = 0;
        src_no_idle    = 1'b0;
        sink_steady    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_default_ports();
        test_port_settings();
        test_output_backpressure();
        test_back_to_back();
        wait_idle();

        if (pending_verdicts.size() != 0) begin
            $error("verdicts: %0d expected but never received", pending_verdicts.size());
            fail_count++;
        end
        $display("Sent %0d payload bytes under %0d port settings, with stalls on both sides.",
                 bytes_accepted, settings_used);
        $display("Verdicts checked: %0d detected, %0d recorded, %0d excluded, %0d skipped.",
                 verdict_seen[VERDICT_DETECT], verdict_seen[VERDICT_RECORD],
                 verdict_seen[VERDICT_EXCLUDE], verdict_seen[VERDICT_SKIP]);
        if (fail_count == 0) begin
            $display("snmp_flow_detector: match");
        end else begin
            $display("snmp_flow_detector: mismatch");
        end
        $finish;
    end

endmodule

// ===== snmp_flow_detector.f =====
rtl/sfd_pkg.sv
rtl/sfd_item_if.sv
rtl/sfd_result_if.sv
rtl/snmp_flow_detector.sv
verif/snmp_flow_detector_tb.sv
